// ===== rtl/core/bone_slot_resolver_top_defines.svh =====
// Assertion macros used by the bone slot resolver top level.
`ifndef BONE_SLOT_RESOLVER_TOP_DEFINES_SVH
`define BONE_SLOT_RESOLVER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSR_ASSERT_SAME(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSR_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bsr_pkg.sv =====
// Types and constants shared by the bone slot resolver modules.
package bsr_pkg;

  // Width of the table count register and of the probe counter.
  localparam int unsigned CNT_W = 9;

  // Identifier hash of the root bone, which maps to pose slot zero unless the bone is masked.
  localparam logic [31:0] ROOT_HASH = 32'hB6C6_5665;

  // Result slot value meaning no slot.
  localparam logic signed [16:0] SLOT_NONE = -17'sd1;

  // Operation codes of an input beat.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_FLAG_MASK    = 2'd0;
  localparam logic [1:0] REG_LOD_DISTANCE = 2'd1;
  localparam logic [1:0] REG_TABLE_COUNT  = 2'd2;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK
  } state_t;

  // Outcome of comparing one table entry with the bone being searched for.
  typedef struct packed {
    logic        hit;
    logic        active;
    logic [15:0] slot;
  } probe_t;

endpackage

// ===== rtl/core/bone_slot_resolver_top.sv =====
// Top level of the bone slot resolver: command interface, search sequencer and registers.
//
// A load beat writes one skeleton entry; it gives no result. A lookup beat gives exactly
// one result, strobed by out_valid for a single cycle, which the receiver cannot stall.
// A masked bone, the root bone or an empty table resolves in the cycle after the beat is
// accepted. Otherwise the table is searched one entry at a time from the resume position,
// each entry taking a memory read, then the compare; a miss searches count entries, count
// being the table count clamped to TABLE_DEPTH. The single read port of the table memory
// sets the pace of the search. busy is high while a search runs; start is ignored then.
// The table needs no clearing after reset: entries must be loaded before a search can
// reach them.
module bone_slot_resolver_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // Command channel.
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [7:0]          in_entry_slot,
  input  logic [31:0]         in_bone_hash,
  input  logic [31:0]         in_entry_lod_limit,
  input  logic [15:0]         in_entry_out_slot,
  input  logic [7:0]          in_bone_flags,
  input  logic                in_first_bone,
  // Result channel.
  output logic                out_valid,
  output logic signed [16:0]  out_slot_index,
  output logic [7:0]          out_flags_echo,
  // Configuration port.
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  `include "bone_slot_resolver_top_defines.svh"

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = bsr_pkg::CNT_W;

  // Configuration registers.
  logic [7:0]        flag_mask_r;
  logic [31:0]       lod_distance_r;
  logic [CNT_W-1:0]  table_count_r;

  // Sequencer and datapath registers.
  bsr_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     resume_r, resume_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]  probe_cnt_r, probe_cnt_nxt;
  logic [31:0]       hash_r, hash_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [16:0] slot_r, slot_nxt;

  // Decoded conditions.
  logic              accept;
  logic              is_lookup;
  logic              masked;
  logic              is_root;
  logic [CNT_W-1:0]  count_eff;
  logic              count_zero;
  logic              search_go;
  logic              last_probe;
  logic [AW-1:0]     resume_eff;
  logic [AW-1:0]     start_pos;
  logic [AW-1:0]     pos_wrap;
  logic              load_ok;
  logic              rd_en;
  bsr_pkg::probe_t   probe;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_mask_r    <= '0;
      lod_distance_r <= '0;
      table_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsr_pkg::REG_FLAG_MASK:    flag_mask_r    <= cfg_wdata[7:0];
        bsr_pkg::REG_LOD_DISTANCE: lod_distance_r <= cfg_wdata;
        bsr_pkg::REG_TABLE_COUNT:  table_count_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode and the quick outcomes that need no search.
  assign accept     = start && !busy;
  assign is_lookup  = (in_operation == bsr_pkg::OP_LOOKUP);
  assign masked     = ((in_bone_flags & flag_mask_r) == 8'd0);
  assign is_root    = (in_bone_hash == bsr_pkg::ROOT_HASH);
  assign count_eff  = (32'(table_count_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                        : table_count_r;
  assign count_zero = (count_eff == '0);
  assign search_go  = accept && is_lookup && !masked && !is_root && !count_zero;
  assign load_ok    = accept && !is_lookup && (32'(in_entry_slot) < TABLE_DEPTH);

  // Search position arithmetic: start point, wraparound step and end of the sweep.
  assign resume_eff = in_first_bone ? '0 : resume_r;
  assign start_pos  = (32'(resume_eff) >= 32'(count_eff)) ? '0 : resume_eff;
  assign pos_wrap   = (32'(pos_r) + 32'd1 >= 32'(count_eff)) ? '0 : AW'(pos_r + 1'b1);
  assign last_probe = (CNT_W'(probe_cnt_r + 1'b1) >= count_eff);

  // Next state of the search sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsr_pkg::ST_IDLE: begin
        if (search_go) begin
          state_nxt = bsr_pkg::ST_FETCH;
        end
      end
      bsr_pkg::ST_FETCH: begin
        state_nxt = bsr_pkg::ST_CHECK;
      end
      bsr_pkg::ST_CHECK: begin
        if (probe.hit || last_probe) begin
          state_nxt = bsr_pkg::ST_IDLE;
        end else begin
          state_nxt = bsr_pkg::ST_FETCH;
        end
      end
      default: state_nxt = bsr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    unique case (state_r)
      bsr_pkg::ST_IDLE:  busy  = 1'b0;
      bsr_pkg::ST_FETCH: rd_en = 1'b1;
      bsr_pkg::ST_CHECK: ;
      default:           busy  = 1'b1;
    endcase
  end

  // Datapath next values: quick results at acceptance, search results after a compare.
  always_comb begin
    resume_nxt    = resume_r;
    pos_nxt       = pos_r;
    probe_cnt_nxt = probe_cnt_r;
    hash_nxt      = hash_r;
    flags_nxt     = flags_r;
    out_valid_nxt = 1'b0;
    slot_nxt      = slot_r;
    if (accept && is_lookup) begin
      hash_nxt  = in_bone_hash;
      flags_nxt = in_bone_flags;
      if (in_first_bone) begin
        resume_nxt = '0;
      end
      priority if (masked) begin
        out_valid_nxt = 1'b1;
        slot_nxt      = bsr_pkg::SLOT_NONE;
      end else if (is_root) begin
        out_valid_nxt = 1'b1;
        slot_nxt      = '0;
      end else if (count_zero) begin
        out_valid_nxt = 1'b1;
        slot_nxt      = bsr_pkg::SLOT_NONE;
      end else begin
        pos_nxt       = start_pos;
        probe_cnt_nxt = '0;
      end
    end else if (state_r == bsr_pkg::ST_CHECK) begin
      priority if (probe.hit) begin
        out_valid_nxt = 1'b1;
        slot_nxt      = probe.active ? $signed({1'b0, probe.slot}) : bsr_pkg::SLOT_NONE;
        resume_nxt    = pos_wrap;
      end else if (last_probe) begin
        out_valid_nxt = 1'b1;
        slot_nxt      = bsr_pkg::SLOT_NONE;
      end else begin
        pos_nxt       = pos_wrap;
        probe_cnt_nxt = CNT_W'(probe_cnt_r + 1'b1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsr_pkg::ST_IDLE;
      resume_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    hash_r      <= hash_nxt;
    flags_r     <= flags_nxt;
    slot_r      <= slot_nxt;
  end

  // Skeleton table and its compare unit.
  bsr_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk          (clk),
    .wr_en        (load_ok),
    .wr_addr      (AW'(in_entry_slot)),
    .wr_hash      (in_bone_hash),
    .wr_limit     (in_entry_lod_limit),
    .wr_slot      (in_entry_out_slot),
    .rd_en        (rd_en),
    .rd_addr      (pos_r),
    .key_hash     (hash_r),
    .lod_distance (lod_distance_r),
    .probe        (probe)
  );

  assign out_valid      = out_valid_r;
  assign out_slot_index = slot_r;
  assign out_flags_echo = flags_r;

  // Sequencer checks.
  `BSR_ASSERT_SAME(a_probe_in_range, clk, rst_n,
    state_r != bsr_pkg::ST_IDLE, probe_cnt_r < count_eff && 32'(pos_r) < 32'(count_eff),
    "search probe counter or position beyond the table count")
  `BSR_ASSERT_NEXT(a_hit_gives_result, clk, rst_n,
    state_r == bsr_pkg::ST_CHECK && probe.hit, out_valid && state_r == bsr_pkg::ST_IDLE,
    "a table hit did not end the search with a result")
  `BSR_ASSERT_NEXT(a_load_silent, clk, rst_n,
    accept && !is_lookup, !out_valid,
    "a load beat produced a result")
  `BSR_ASSERT_NEXT(a_quick_result, clk, rst_n,
    accept && is_lookup && !search_go, out_valid && state_r == bsr_pkg::ST_IDLE,
    "a lookup that needs no search did not give its result at once")

endmodule

// ===== rtl/core/bsr_table.sv =====
// Skeleton table memory with its registered read port and the entry compare unit.
module bsr_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [31:0]         wr_hash,
  input  logic [31:0]         wr_limit,
  input  logic [15:0]         wr_slot,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic [31:0]         key_hash,
  input  logic [31:0]         lod_distance,
  output bsr_pkg::probe_t     probe
);

  localparam int unsigned ENTRY_W = 32 + 32 + 16;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [31:0]        rd_hash;
  logic [31:0]        rd_limit;
  logic [15:0]        rd_slot;

  // Single write port, filled by load beats.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_hash, wr_limit, wr_slot};
    end
  end

  // Registered read port, one entry per fetch.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_hash  = rd_data_r[ENTRY_W-1 -: 32];
  assign rd_limit = rd_data_r[47:16];
  assign rd_slot  = rd_data_r[15:0];

  // Shared compare unit: identifier match and distance check on the fetched entry.
  always_comb begin
    probe.hit    = (rd_hash == key_hash);
    probe.active = (lod_distance <= rd_limit);
    probe.slot   = rd_slot;
  end

endmodule
